// File: rtl/altaz_pkg.sv
`default_nettype none
package altaz_pkg;

    localparam int OutWidth      = 16;
    localparam int AngleFracBits = 6;
    localparam int AltWidth      = 14;
    localparam int AngWidth      = 15;
    localparam int FullTurn      = 360 << AngleFracBits;
    localparam int HalfTurn      = 180 << AngleFracBits;
    localparam int QuarterTurn   = 90 << AngleFracBits;
    localparam int EighthTurn    = 45 << AngleFracBits;
    localparam int NumEntries    = EighthTurn + 1;
    localparam int EntryBits     = $clog2(NumEntries);
    localparam int MagBits       = 31;

    typedef logic [AngWidth-1:0] t_angle;
    typedef logic [MagBits-1:0]  t_mag;

    typedef struct packed {
        logic [EntryBits-1:0] idx;
        logic                 use_cos;
        logic                 neg;
    } t_fold;

    function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] rem;
        q   = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem  = rem - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] series(input logic [63:0] x, input logic odd);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] n;
        logic [63:0] sum;
        x2   = (x * x) >> 30;
        term = odd ? x : 64'd1 << 30;
        n    = odd ? 64'd1 : 64'd0;
        sum  = term;
        for (int i = 0; i < 6; i++) begin
            term = udiv((term * x2) >> 30, (n + 64'd1) * (n + 64'd2));
            n    = n + 64'd2;
            if (i % 2 == 1) sum = sum + term;
            else            sum = sum - term;
        end
        return sum;
    endfunction

    function automatic t_mag sin_entry(input int t);
        logic [63:0] r;
        r = udiv(64'(t) * 64'd3373259426, 64'(HalfTurn));
        return MagBits'(series(r, 1'b1));
    endfunction

    function automatic t_mag cos_entry(input int t);
        logic [63:0] r;
        r = udiv(64'(t) * 64'd3373259426, 64'(HalfTurn));
        return MagBits'(series(r, 1'b0));
    endfunction

endpackage
`default_nettype wire

// File: rtl/altaz_sine.sv
`default_nettype none
module altaz_sine (
    input  wire logic                  i_clk,
    input  wire altaz_pkg::t_angle     i_angle,
    output altaz_pkg::t_mag            o_mag,
    output logic                       o_neg
);

    altaz_pkg::t_mag sin_rom [altaz_pkg::NumEntries];
    altaz_pkg::t_mag cos_rom [altaz_pkg::NumEntries];

    always_comb begin
        for (int k = 0; k < altaz_pkg::NumEntries; k++) begin
            sin_rom[k] = altaz_pkg::sin_entry(k);
            cos_rom[k] = altaz_pkg::cos_entry(altaz_pkg::EighthTurn - k);
        end
    end

    altaz_pkg::t_fold n_fold;
    altaz_pkg::t_fold r_fold;
    altaz_pkg::t_angle t;

    always_comb begin
        t = i_angle;
        n_fold.neg = (t >= altaz_pkg::AngWidth'(altaz_pkg::HalfTurn));
        if (n_fold.neg) t = t - altaz_pkg::AngWidth'(altaz_pkg::HalfTurn);
        if (t > altaz_pkg::AngWidth'(altaz_pkg::QuarterTurn))
            t = altaz_pkg::AngWidth'(altaz_pkg::HalfTurn) - t;
        n_fold.use_cos = (t > altaz_pkg::AngWidth'(altaz_pkg::EighthTurn));
        if (n_fold.use_cos) n_fold.idx = altaz_pkg::EntryBits'(
            altaz_pkg::AngWidth'(altaz_pkg::QuarterTurn) - t);
        else n_fold.idx = altaz_pkg::EntryBits'(t);
    end

    always_ff @(posedge i_clk) begin
        r_fold <= n_fold;
    end

    always_ff @(posedge i_clk) begin
        o_mag <= r_fold.use_cos ? cos_rom[altaz_pkg::EntryBits'(
                 altaz_pkg::EighthTurn) - r_fold.idx] : sin_rom[r_fold.idx];
        o_neg <= r_fold.neg;
    end

endmodule
`default_nettype wire

// File: rtl/altaz_to_detector_vector_top.sv
// Channel   | Direction | Handshake                 | Payload
// command   | in        | i_start / o_busy          | i_altitude, i_azimuth
// config    | in        | i_cfg_we                  | i_cfg_wdata (detector_heading)
// result    | out       | o_result_valid (strobe)   | o_x_component, o_y/z_component
// One item per cycle; the result follows the start transfer through a registered pipeline.
// Depth is set by angle reduction, two-stage sine lookup, product and rounding.
// o_busy is held low: there is no stall. Synchronous active-low reset clears
// the valid chain and the heading register.
`default_nettype none
module altaz_to_detector_vector_top (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    output logic                      o_busy,
    input  wire logic signed [13:0]   i_altitude,
    input  wire logic        [14:0]   i_azimuth,
    input  wire logic                 i_cfg_we,
    input  wire logic        [14:0]   i_cfg_wdata,
    output logic                      o_result_valid,
    output logic signed [15:0]        o_x_component,
    output logic signed [15:0]        o_y_component,
    output logic signed [15:0]        o_z_component
);

    localparam int W = altaz_pkg::AngWidth;
    localparam logic [W-1:0] Full = W'(altaz_pkg::FullTurn);
    localparam logic [W-1:0] Quar = W'(altaz_pkg::QuarterTurn);

    logic [W-1:0] r_heading;
    logic [4:0]   r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heading <= '0;
            r_valid   <= '0;
        end else begin
            if (i_cfg_we) r_heading <= i_cfg_wdata;
            r_valid <= {r_valid[3:0], i_start};
        end
    end

    assign o_busy = 1'b0;

    // Stage 1: reduce angles
    logic [W-1:0] az_m, hd_m, n_a, n_d;
    logic signed [W:0] alt_w;
    always_comb begin
        az_m = (i_azimuth >= Full) ? i_azimuth - Full : i_azimuth;
        hd_m = (r_heading >= Full) ? r_heading - Full : r_heading;
        alt_w = (W+1)'(i_altitude);
        if (alt_w < 0) alt_w = alt_w + (W+1)'(altaz_pkg::FullTurn);
        n_a = W'(alt_w);
        n_d = (az_m >= hd_m) ? az_m - hd_m : az_m + Full - hd_m;
    end

    logic [W-1:0] r_a, r_d, r_ac, r_dc;
    always_ff @(posedge i_clk) begin
        r_a  <= n_a;
        r_d  <= n_d;
        r_ac <= (n_a >= Full - Quar) ? n_a - (Full - Quar) : n_a + Quar;
        r_dc <= (n_d >= Full - Quar) ? n_d - (Full - Quar) : n_d + Quar;
    end

    altaz_pkg::t_mag sa_m, ca_m, sd_m, cd_m;
    logic sa_n, ca_n, sd_n, cd_n;
    altaz_sine u_sa (.i_clk, .i_angle(r_a),  .o_mag(sa_m), .o_neg(sa_n));
    altaz_sine u_ca (.i_clk, .i_angle(r_ac), .o_mag(ca_m), .o_neg(ca_n));
    altaz_sine u_sd (.i_clk, .i_angle(r_d),  .o_mag(sd_m), .o_neg(sd_n));
    altaz_sine u_cd (.i_clk, .i_angle(r_dc), .o_mag(cd_m), .o_neg(cd_n));

    // Stage 4: products
    logic [61:0] r_px, r_pz;
    logic [30:0] r_sa;
    logic r_xn, r_zn, r_yn;
    always_ff @(posedge i_clk) begin
        r_px <= 62'(ca_m) * 62'(sd_m);
        r_pz <= 62'(ca_m) * 62'(cd_m);
        r_sa <= sa_m;
        r_xn <= ca_n ^ sd_n;
        r_zn <= ~(ca_n ^ cd_n);
        r_yn <= ~sa_n;
    end

    function automatic logic [15:0] to_out(input logic [30:0] m, input logic neg);
        logic [16:0] q;
        q = 17'((32'(m) + 32'd16384) >> 15);
        if (q > 17'd32767) q = 17'd32767;
        return neg ? 16'(-q) : 16'(q);
    endfunction

    logic [30:0] mx, mz;
    assign mx = 31'((r_px + 62'd536870912) >> 30);
    assign mz = 31'((r_pz + 62'd536870912) >> 30);

    always_ff @(posedge i_clk) begin
        o_x_component <= to_out(mx, r_xn);
        o_y_component <= to_out(r_sa, r_yn);
        o_z_component <= to_out(mz, r_zn);
    end

    assign o_result_valid = r_valid[4];

endmodule
`default_nettype wire
